// ===== hw/rtl/bc_pkg.sv =====
// Shared types and constants for the binomial coefficient block.
package bc_pkg;

  // Width of the input ports and of the divider's divisor path
  localparam int unsigned PortW = 32;
  // Width of the result and of the running product
  localparam int unsigned ResW = 64;

  // Class of an accepted item, decided by the front end
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_ONE,
    KIND_RUN
  } kind_e;

  // Request to the shared divider
  typedef struct packed {
    logic             start;
    logic [ResW-1:0]  dividend;
    logic [PortW-1:0] divisor;
  } div_req_t;

  // Answer from the shared divider
  typedef struct packed {
    logic             done;
    logic [ResW-1:0]  quot;
    logic [PortW-1:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/binomial_coefficient_u64.sv =====
// Top level of the binomial coefficient block: front end, queue, back end.
//
// Usage: drive n_total_i and k_choose_i with start high; the item transfers
// at a rising edge where start is high and busy is low. Each item yields
// exactly one result: coefficient_o is valid for the single cycle where
// done_o is high, and is taken at the edge ending that cycle. The receiver
// cannot stall; results leave in the order items were accepted.
// Only the low ARG_WIDTH bits of each operand are used.
// Items with k > n, k = 0 or k = n skip the steps: the idle back end sets the
// result straight from the queue. Otherwise each of the min(k, n-k) steps runs
// two Euclid gcds (one division per remainder) and four or five further
// divisions on one shared radix-2 divider, then a split 32-bit multiply (low
// half, high half, add). At most 34 steps run before the result or an overflow.
// The divider sets the throughput; a two-entry queue lets up to two further
// items be accepted while one is worked on, and busy rises when it fills.
// Reset (rst_ni low, asynchronous) empties the queue and idles the sequencer.
module binomial_coefficient_u64 #(
  parameter int unsigned ARG_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [bc_pkg::PortW-1:0]        n_total_i,
  input  logic [bc_pkg::PortW-1:0]        k_choose_i,
  output logic                            done_o,
  output logic [bc_pkg::ResW-1:0]         coefficient_o
);

  localparam int unsigned ItemW = $bits(bc_pkg::kind_e) + 2 * ARG_WIDTH;

  bc_pkg::kind_e        f_kind;
  logic [ARG_WIDTH-1:0] f_n, f_k;
  logic [ItemW-1:0]     q_out;
  logic                 q_empty, q_full, pop;
  logic                 push;

  assign busy   = q_full;
  assign push   = start && !q_full;

  bc_front #(.ARG_WIDTH(ARG_WIDTH)) u_front (
    .n_total_i  (n_total_i),
    .k_choose_i (k_choose_i),
    .kind_o     (f_kind),
    .n_o        (f_n),
    .k_o        (f_k)
  );

  bc_queue #(.WIDTH(ItemW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_kind, f_n, f_k}),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  bc_back #(.ARG_WIDTH(ARG_WIDTH)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .kind_i        (bc_pkg::kind_e'(q_out[ItemW-1 -: $bits(bc_pkg::kind_e)])),
    .n_i           (q_out[2*ARG_WIDTH-1:ARG_WIDTH]),
    .k_i           (q_out[ARG_WIDTH-1:0]),
    .pop_o         (pop),
    .done_o        (done_o),
    .coefficient_o (coefficient_o)
  );

endmodule

// ===== hw/rtl/bc_front.sv =====
// Front end: masks the operands and sorts each item into trivial or iterative work.
module bc_front #(
  parameter int unsigned ARG_WIDTH = 32
) (
  input  logic [bc_pkg::PortW-1:0] n_total_i,
  input  logic [bc_pkg::PortW-1:0] k_choose_i,
  output bc_pkg::kind_e            kind_o,
  output logic [ARG_WIDTH-1:0]     n_o,
  output logic [ARG_WIDTH-1:0]     k_o
);

  logic [ARG_WIDTH-1:0] n_m;
  logic [ARG_WIDTH-1:0] k_m;
  logic [ARG_WIDTH-1:0] nk;

  assign n_m = n_total_i[ARG_WIDTH-1:0];
  assign k_m = k_choose_i[ARG_WIDTH-1:0];
  assign nk  = n_m - k_m;
  assign n_o = n_m;

  // Fold k onto the smaller side and classify
  always_comb begin
    k_o = (k_m > nk) ? nk : k_m;
    if (k_m > n_m) begin
      kind_o = bc_pkg::KIND_ZERO;
    end else if (k_o == '0) begin
      kind_o = bc_pkg::KIND_ONE;
    end else begin
      kind_o = bc_pkg::KIND_RUN;
    end
  end

endmodule

// ===== hw/rtl/bc_queue.sv =====
// Two-entry queue between the front end and the back end.
module bc_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold entry payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/bc_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module bc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bc_pkg::div_req_t  req_i,
  output bc_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned CntW = $clog2(bc_pkg::ResW);

  logic                     busy_q;
  logic                     done_q;
  logic [CntW-1:0]          cnt_q;
  logic [bc_pkg::ResW-1:0]  dvd_q, dvd_d;
  logic [bc_pkg::PortW-1:0] dvs_q;
  logic [bc_pkg::PortW-1:0] rem_q, rem_d;
  logic [bc_pkg::PortW:0]   trial;
  logic                     ge;

  // Trial subtract of the next partial remainder
  always_comb begin
    trial = {rem_q, dvd_q[bc_pkg::ResW-1]};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? bc_pkg::PortW'(trial - {1'b0, dvs_q}) : trial[bc_pkg::PortW-1:0];
    dvd_d = {dvd_q[bc_pkg::ResW-2:0], ge};
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(bc_pkg::ResW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift one bit a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

endmodule

// ===== hw/rtl/bc_back.sv =====
// Back end: step sequencer with gcd cancellation, shared divider and split multiply.
module bc_back #(
  parameter int unsigned ARG_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  input  bc_pkg::kind_e           kind_i,
  input  logic [ARG_WIDTH-1:0]    n_i,
  input  logic [ARG_WIDTH-1:0]    k_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic [bc_pkg::ResW-1:0] coefficient_o
);

  localparam int unsigned PW = bc_pkg::PortW;
  localparam int unsigned RW = bc_pkg::ResW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_G1, ST_G1W, ST_RDIV, ST_D1, ST_G2, ST_G2W,
    ST_NDIV, ST_D2, ST_LDIV, ST_MLO, ST_MHI, ST_MADD
  } state_e;

  state_e               state_q;
  logic [ARG_WIDTH-1:0] n_q, k_q, step_q;
  logic [RW-1:0]        r_q, x_q;
  logic [PW-1:0]        y_q, g_q, num_q, den_q;
  logic [RW-1:0]        mlo_q, mhi_q;
  logic                 done_q;
  logic [RW-1:0]        res_q;
  bc_pkg::div_req_t     req_q;
  bc_pkg::div_rsp_t     rsp;
  logic [RW+PW-1:0]     prod;
  logic [ARG_WIDTH-1:0] step_nx;

  bc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  assign pop_o         = (state_q == ST_IDLE) && !empty_i;
  assign done_o        = done_q;
  assign coefficient_o = res_q;
  assign prod          = {mhi_q, {PW{1'b0}}} + (RW+PW)'(mlo_q);
  assign step_nx       = step_q + 1'b1;

  // Sequence one item: answer trivial kinds directly; else gcd, cancel, multiply, repeat per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      req_q     <= '0;
    end else begin
      done_q      <= 1'b0;
      req_q.start <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            unique case (kind_i)
              bc_pkg::KIND_ZERO: begin
                res_q  <= '0;
                done_q <= 1'b1;
              end
              bc_pkg::KIND_ONE: begin
                res_q  <= RW'(1);
                done_q <= 1'b1;
              end
              default: begin
                n_q     <= n_i;
                k_q     <= k_i;
                step_q  <= '0;
                r_q     <= RW'(1);
                num_q   <= PW'(n_i);
                den_q   <= PW'(1);
                x_q     <= RW'(1);
                y_q     <= PW'(1);
                state_q <= ST_G1;
              end
            endcase
          end
        end
        ST_G1: begin
          req_q.start <= 1'b1;
          if (y_q == '0) begin
            g_q            <= x_q[PW-1:0];
            req_q.dividend <= r_q;
            req_q.divisor  <= x_q[PW-1:0];
            state_q        <= ST_RDIV;
          end else begin
            req_q.dividend <= x_q;
            req_q.divisor  <= y_q;
            state_q        <= ST_G1W;
          end
        end
        ST_G1W: begin
          if (rsp.done) begin
            x_q     <= RW'(y_q);
            y_q     <= rsp.rem;
            state_q <= ST_G1;
          end
        end
        ST_RDIV: begin
          if (rsp.done) begin
            r_q            <= rsp.quot;
            req_q.start    <= 1'b1;
            req_q.dividend <= RW'(den_q);
            req_q.divisor  <= g_q;
            state_q        <= ST_D1;
          end
        end
        ST_D1: begin
          if (rsp.done) begin
            den_q   <= rsp.quot[PW-1:0];
            x_q     <= RW'(num_q);
            y_q     <= rsp.quot[PW-1:0];
            state_q <= ST_G2;
          end
        end
        ST_G2: begin
          req_q.start <= 1'b1;
          if (y_q == '0) begin
            g_q            <= x_q[PW-1:0];
            req_q.dividend <= RW'(num_q);
            req_q.divisor  <= x_q[PW-1:0];
            state_q        <= ST_NDIV;
          end else begin
            req_q.dividend <= x_q;
            req_q.divisor  <= y_q;
            state_q        <= ST_G2W;
          end
        end
        ST_G2W: begin
          if (rsp.done) begin
            x_q     <= RW'(y_q);
            y_q     <= rsp.rem;
            state_q <= ST_G2;
          end
        end
        ST_NDIV: begin
          if (rsp.done) begin
            num_q          <= rsp.quot[PW-1:0];
            req_q.start    <= 1'b1;
            req_q.dividend <= RW'(den_q);
            req_q.divisor  <= g_q;
            state_q        <= ST_D2;
          end
        end
        ST_D2: begin
          if (rsp.done) begin
            den_q <= rsp.quot[PW-1:0];
            // Divide out any leftover divisor
            if (rsp.quot > RW'(1)) begin
              req_q.start    <= 1'b1;
              req_q.dividend <= r_q;
              req_q.divisor  <= rsp.quot[PW-1:0];
              state_q        <= ST_LDIV;
            end else begin
              state_q <= ST_MLO;
            end
          end
        end
        ST_LDIV: begin
          if (rsp.done) begin
            r_q     <= rsp.quot;
            state_q <= ST_MLO;
          end
        end
        ST_MLO: begin
          mlo_q   <= RW'(r_q[PW-1:0]) * RW'(num_q);
          state_q <= ST_MHI;
        end
        ST_MHI: begin
          mhi_q   <= RW'(r_q[RW-1:PW]) * RW'(num_q);
          state_q <= ST_MADD;
        end
        ST_MADD: begin
          if (prod[RW+PW-1:RW] != '0) begin
            // On overflow, end the item with a result of zero
            res_q   <= '0;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (step_nx == k_q) begin
            res_q   <= prod[RW-1:0];
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            r_q     <= prod[RW-1:0];
            step_q  <= step_nx;
            num_q   <= PW'(n_q - step_nx);
            den_q   <= PW'(step_nx) + PW'(1);
            x_q     <= prod[RW-1:0];
            y_q     <= PW'(step_nx) + PW'(1);
            state_q <= ST_G1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
